[rtl/core/agg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the audio gate, gain and peak detect block.
// Depends on nothing; every other file of the block imports it.
package agg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int GAIN_W   = 8;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S16_MIN = -16'sh8000;
    localparam logic [MAG_W-1:0]           MAG_MAX = 15'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_GATE     = 2'd0,
        CFG_GAIN           = 2'd1,
        CFG_SEND_THRESHOLD = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [MAG_W-1:0]  noise_gate;
        logic [GAIN_W-1:0] gain;
        logic [MAG_W-1:0]  send_threshold;
    } t_cfg;

    // Gated and amplified sample before saturation, with its block mark.
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic                     last;
    } t_prod_item;

endpackage

[rtl/core/agg_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one raw audio sample and its last-of-block mark per transfer.
// Depends on agg_pkg.
interface agg_in_if;
    import agg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in_block;

    modport source (output valid, output sample_in, output last_in_block, input ready);
    modport sink   (input valid, input sample_in, input last_in_block, output ready);
endinterface

[rtl/core/agg_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one processed sample, with block peak and send flag at block end.
// Depends on agg_pkg.
interface agg_out_if;
    import agg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end;
    logic [MAG_W-1:0]           block_peak;
    logic                       send_block;

    modport source (output valid, output sample_out, output block_end,
                    output block_peak, output send_block, input ready);
    modport sink   (input valid, input sample_out, input block_end,
                    input block_peak, input send_block, output ready);
endinterface

[rtl/core/audio_gate_gain_peak_detect.sv]
`timescale 1ns / 1ps
// Top level: configuration registers, gate/gain stage and peak stage.
// Depends on agg_pkg, agg_in_if, agg_out_if, agg_gate_mult and agg_peak_track.
//
//   Channel   Direction  Content
//   i_in      in         sample_in (s16), last_in_block
//   o_out     out        sample_out (s16), block_end, block_peak (u15), send_block
//   i_cfg_*   in         write enable, register index, 15-bit data
//
// One sample enters and one result leaves per cycle unless o_out stalls.
// Samples pass through the input register, product register and output register.
// The single multiplier between the input and product registers sets the pace.
// Reset clears the valid bits, the running peak and the registers to defaults.
// A stall on o_out holds every occupied stage; empty stages still fill.
module audio_gate_gain_peak_detect (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    agg_in_if.sink                          i_in,
    agg_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [agg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [agg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import agg_pkg::*;

    t_cfg       r_cfg;
    logic       mid_vld;
    logic       mid_rdy;
    t_prod_item mid_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_gate     <= '0;
            r_cfg.gain           <= GAIN_W'(1);
            r_cfg.send_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NOISE_GATE:     r_cfg.noise_gate     <= i_cfg_data[MAG_W-1:0];
                CFG_GAIN:           r_cfg.gain           <= i_cfg_data[GAIN_W-1:0];
                CFG_SEND_THRESHOLD: r_cfg.send_threshold <= i_cfg_data[MAG_W-1:0];
                default: begin
                    // Writes to an unused index are dropped.
                end
            endcase
        end
    end

    agg_gate_mult u_gate_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_vld   (mid_vld),
        .o_item  (mid_item),
        .i_rdy   (mid_rdy)
    );

    agg_peak_track u_peak_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (mid_vld),
        .i_item  (mid_item),
        .o_rdy   (mid_rdy),
        .o_out   (o_out)
    );

endmodule

[rtl/core/agg_gate_mult.sv]
`timescale 1ns / 1ps
// Input register, then noise gate and gain multiply into the product register.
// Depends on agg_pkg and agg_in_if.
module agg_gate_mult (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  agg_pkg::t_cfg      i_cfg,
    agg_in_if.sink             i_in,
    output logic               o_vld,
    output agg_pkg::t_prod_item o_item,
    input  logic               i_rdy
);
    import agg_pkg::*;

    logic                       r_a_vld;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic                       r_a_last;
    logic                       r_b_vld;
    t_prod_item                 r_b_item;
    t_prod_item                 n_b_item;
    logic                       b_rdy;
    logic                       a_rdy;
    logic [SAMPLE_W:0]          a_mag;

    assign b_rdy      = !r_b_vld || i_rdy;
    assign a_rdy      = !r_a_vld || b_rdy;
    assign i_in.ready = a_rdy;

    // Magnitude needs one extra bit so that the most negative sample is exact.
    assign a_mag = r_a_sample[SAMPLE_W-1] ? -{r_a_sample[SAMPLE_W-1], r_a_sample}
                                          :  {r_a_sample[SAMPLE_W-1], r_a_sample};

    always_comb begin
        n_b_item.last = r_a_last;
        if (a_mag < {2'b00, i_cfg.noise_gate}) begin
            n_b_item.prod = '0;
        end else begin
            n_b_item.prod = r_a_sample * $signed({1'b0, i_cfg.gain});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_a_vld <= i_in.valid;
            end
            if (b_rdy) begin
                r_b_vld <= r_a_vld;
            end
        end
        if (a_rdy && i_in.valid) begin
            r_a_sample <= i_in.sample_in;
            r_a_last   <= i_in.last_in_block;
        end
        if (b_rdy && r_a_vld) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_item = r_b_item;

endmodule

[rtl/core/agg_peak_track.sv]
`timescale 1ns / 1ps
// Saturation, running block peak and the output register.
// Depends on agg_pkg and agg_out_if.
module agg_peak_track (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  agg_pkg::t_cfg      i_cfg,
    input  logic               i_vld,
    input  agg_pkg::t_prod_item i_item,
    output logic               o_rdy,
    agg_out_if.source          o_out
);
    import agg_pkg::*;

    logic                       r_vld;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_end;
    logic [MAG_W-1:0]           r_peak_out;
    logic                       r_send;
    logic [MAG_W-1:0]           r_peak;
    logic signed [SAMPLE_W-1:0] y;
    logic [MAG_W-1:0]           y_mag;
    logic [MAG_W-1:0]           n_peak;
    logic                       adv;

    assign o_rdy = !r_vld || o_out.ready;
    assign adv   = o_rdy && i_vld;

    always_comb begin
        if (i_item.prod > PROD_W'(S16_MAX)) begin
            y = S16_MAX;
        end else if (i_item.prod < PROD_W'(S16_MIN)) begin
            y = S16_MIN;
        end else begin
            y = i_item.prod[SAMPLE_W-1:0];
        end
    end

    // The most negative sample counts as full scale in the peak.
    always_comb begin
        priority if (y == S16_MIN) begin
            y_mag = MAG_MAX;
        end else if (y[SAMPLE_W-1]) begin
            y_mag = MAG_W'(-y);
        end else begin
            y_mag = y[MAG_W-1:0];
        end
    end

    assign n_peak = (y_mag > r_peak) ? y_mag : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_peak <= '0;
        end else begin
            if (o_rdy) begin
                r_vld <= i_vld;
            end
            if (adv) begin
                r_peak <= i_item.last ? '0 : n_peak;
            end
        end
        if (adv) begin
            r_sample   <= y;
            r_end      <= i_item.last;
            r_peak_out <= i_item.last ? n_peak : '0;
            r_send     <= i_item.last && (n_peak >= i_cfg.send_threshold);
        end
    end

    assign o_out.valid      = r_vld;
    assign o_out.sample_out = r_sample;
    assign o_out.block_end  = r_end;
    assign o_out.block_peak = r_peak_out;
    assign o_out.send_block = r_send;

    a_peak_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && i_item.last |=> r_peak == '0)
        else $error("running peak not cleared after block end");

    a_mid_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_end |-> r_peak_out == '0 && !r_send)
        else $error("peak or send flag set on a mid-block result");

    a_send_meets_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_send |-> r_peak_out >= i_cfg.send_threshold)
        else $error("send flag set below threshold");

    a_peak_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !i_item.last |=> r_peak >= $past(r_peak))
        else $error("running peak decreased inside a block");

endmodule
